/* hdl/suwl_pkg.sv */
// Shared types and constants for the sorted unique word list unit.
package suwl_pkg;

   localparam int WORD_BYTES = 20;
   localparam int WORD_BITS  = 8 * WORD_BYTES;

   typedef struct packed {
      logic [31:0] tail;
      logic [63:0] middle;
      logic [63:0] head;
   } word_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_result_type;

endpackage

/* hdl/sorted_unique_word_list_unit.sv */
// Top level: collects words, keeps them sorted, emits them deduplicated at list end.
// Ready stays low from acceptance until a word is stored, or dropped by a full list,
// and after a final word until the list has been drained. Each shift step reads one
// memory entry and runs it through the shared comparator. The drain waits while the
// result channel stalls. Reset is synchronous and active high; it empties the list and
// clears the overflow flag.
module sorted_unique_word_list_unit
   import suwl_pkg::*;
#(
   parameter int LIST_CAPACITY = 64
)
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // req_tdata, from bit 0 up: word_head[63:0], word_middle[63:0], word_tail[31:0]
   input  logic [159:0] req_tdata,
   input  logic         req_tlast,    // final_word

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rsp_tdata, from bit 0 up: out_head[63:0], out_middle[63:0], out_tail[31:0]
   output logic [159:0] rsp_tdata,
   output logic         rsp_tlast,    // end_of_list
   output logic         rsp_tuser     // overflowed
);

   // Address width indexes the memory; count width can also hold the capacity itself.
   localparam int AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
   localparam int CW = $clog2(LIST_CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(LIST_CAPACITY);

   typedef enum logic [3:0] {
      S_IDLE,
      S_NORM,
      S_INS_RD,
      S_INS_CMP,
      S_INS_PUT,
      S_DR_RD,
      S_DR_CMP,
      S_FLUSH,
      S_EMIT
   } state_type;

   // A word ends at its first zero byte; every byte after it is forced to zero so
   // that the unsigned compare behaves like a string compare.
   function automatic word_type normalize(input word_type w);
      logic [WORD_BITS-1:0] flat;
      logic [WORD_BITS-1:0] res;
      logic                 alive;
      word_type             r;
      flat  = {w.head, w.middle, w.tail};
      res   = '0;
      alive = 1'b1;
      for (int k = 0; k < WORD_BYTES; k++) begin
         if (flat[WORD_BITS-1-8*k -: 8] == 8'd0) begin
            alive = 1'b0;
         end
         if (alive) begin
            res[WORD_BITS-1-8*k -: 8] = flat[WORD_BITS-1-8*k -: 8];
         end
      end
      r.head   = res[WORD_BITS-1 -: 64];
      r.middle = res[WORD_BITS-65 -: 64];
      r.tail   = res[31:0];
      return r;
   endfunction

   // Word memory: one write port, one registered read port.
   word_type mem [LIST_CAPACITY];

   state_type      state_ff,        state_in;
   word_type       raw_ff,          raw_in;
   logic           final_ff,        final_in;
   word_type       word_ff,         word_in;
   logic [AW-1:0]  pos_ff,          pos_in;
   logic [CW-1:0]  idx_ff,          idx_in;
   logic [CW-1:0]  count_ff,        count_in;
   logic           dropped_ff,      dropped_in;
   word_type       pending_ff,      pending_in;
   logic           have_pending_ff, have_pending_in;
   word_type       rsp_word_ff,     rsp_word_in;
   logic           rsp_tvalid_ff,   rsp_tvalid_in;
   logic           rsp_tlast_ff,    rsp_tlast_in;
   logic           rsp_tuser_ff,    rsp_tuser_in;
   word_type       rd_word_ff;

   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   word_type       mem_wdata;
   logic [AW-1:0]  rd_addr;

   word_type       cmp_a;
   word_type       cmp_b;
   cmp_result_type cmp;

   word_type       req_word;

   assign req_word.head   = req_tdata[63:0];
   assign req_word.middle = req_tdata[127:64];
   assign req_word.tail   = req_tdata[159:128];

   // The comparator is shared: insertion asks whether the new word sorts below the
   // entry just read, the drain asks whether the entry repeats the pending word.
   always_comb begin
      if (state_ff == S_DR_CMP) begin
         cmp_a = rd_word_ff;
         cmp_b = pending_ff;
      end else begin
         cmp_a = word_ff;
         cmp_b = rd_word_ff;
      end
   end

   suwl_compare u_compare (
      .a      (cmp_a),
      .b      (cmp_b),
      .result (cmp)
   );

   always_comb begin
      state_in        = state_ff;
      raw_in          = raw_ff;
      final_in        = final_ff;
      word_in         = word_ff;
      pos_in          = pos_ff;
      idx_in          = idx_ff;
      count_in        = count_ff;
      dropped_in      = dropped_ff;
      pending_in      = pending_ff;
      have_pending_in = have_pending_ff;
      rsp_word_in     = rsp_word_ff;
      rsp_tvalid_in   = rsp_tvalid_ff;
      rsp_tlast_in    = rsp_tlast_ff;
      rsp_tuser_in    = rsp_tuser_ff;
      mem_we          = 1'b0;
      mem_waddr       = pos_ff;
      mem_wdata       = word_ff;
      rd_addr         = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               raw_in   = req_word;
               final_in = req_tlast;
               state_in = S_NORM;
            end
         end

         S_NORM: begin
            word_in = normalize(raw_ff);
            if (count_ff == CAP_COUNT) begin
               // No room: the word is lost, but a final request still drains.
               dropped_in = 1'b1;
               if (final_ff) begin
                  idx_in          = '0;
                  have_pending_in = 1'b0;
                  state_in        = S_DR_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               pos_in = count_ff[AW-1:0];
               if (count_ff == '0) begin
                  state_in = S_INS_PUT;
               end else begin
                  state_in = S_INS_RD;
               end
            end
         end

         S_INS_RD: begin
            rd_addr  = pos_ff - AW'(1);
            state_in = S_INS_CMP;
         end

         S_INS_CMP: begin
            if (cmp.lt) begin
               // Entry below the gap is larger: move it up one place.
               mem_we    = 1'b1;
               mem_waddr = pos_ff;
               mem_wdata = rd_word_ff;
               pos_in    = pos_ff - AW'(1);
               if (pos_ff == AW'(1)) begin
                  state_in = S_INS_PUT;
               end else begin
                  state_in = S_INS_RD;
               end
            end else begin
               state_in = S_INS_PUT;
            end
         end

         S_INS_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = word_ff;
            count_in  = count_ff + CW'(1);
            if (final_ff) begin
               idx_in          = '0;
               have_pending_in = 1'b0;
               state_in        = S_DR_RD;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_DR_RD: begin
            rd_addr  = idx_ff[AW-1:0];
            idx_in   = idx_ff + CW'(1);
            state_in = S_DR_CMP;
         end

         S_DR_CMP: begin
            // One word is held back so that the last unique one can be marked.
            if (have_pending_ff && cmp.eq) begin
               state_in = (idx_ff == count_ff) ? S_FLUSH : S_DR_RD;
            end else if (have_pending_ff) begin
               rsp_word_in   = pending_ff;
               rsp_tlast_in  = 1'b0;
               rsp_tuser_in  = dropped_ff;
               rsp_tvalid_in = 1'b1;
               pending_in    = rd_word_ff;
               state_in      = S_EMIT;
            end else begin
               pending_in      = rd_word_ff;
               have_pending_in = 1'b1;
               state_in        = (idx_ff == count_ff) ? S_FLUSH : S_DR_RD;
            end
         end

         S_FLUSH: begin
            rsp_word_in   = pending_ff;
            rsp_tlast_in  = 1'b1;
            rsp_tuser_in  = dropped_ff;
            rsp_tvalid_in = 1'b1;
            state_in      = S_EMIT;
         end

         S_EMIT: begin
            if (rsp_tready) begin
               rsp_tvalid_in = 1'b0;
               if (rsp_tlast_ff) begin
                  // List delivered: start the next one empty.
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = S_IDLE;
               end else if (idx_ff == count_ff) begin
                  state_in = S_FLUSH;
               end else begin
                  state_in = S_DR_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      raw_ff          <= raw_in;
      final_ff        <= final_in;
      word_ff         <= word_in;
      pos_ff          <= pos_in;
      idx_ff          <= idx_in;
      pending_ff      <= pending_in;
      have_pending_ff <= have_pending_in;
      rsp_word_ff     <= rsp_word_in;
      rsp_tlast_ff    <= rsp_tlast_in;
      rsp_tuser_ff    <= rsp_tuser_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_word_ff <= mem[rd_addr];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_word_ff.tail, rsp_word_ff.middle, rsp_word_ff.head};
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

/* hdl/suwl_compare.sv */
// Shared 160-bit word comparator: head, then middle, then tail, all unsigned.
module suwl_compare
   import suwl_pkg::*;
(
   input  word_type       a,
   input  word_type       b,
   output cmp_result_type result
);

   logic [WORD_BITS-1:0] a_key;
   logic [WORD_BITS-1:0] b_key;

   // Head is most significant, so the key concatenates in string order.
   assign a_key = {a.head, a.middle, a.tail};
   assign b_key = {b.head, b.middle, b.tail};

   assign result.lt = (a_key < b_key);
   assign result.eq = (a_key == b_key);

endmodule
